// ===== design/rmq_pkg.sv =====
// Shared types and constants for the rotation matrix to quaternion pipeline.
// No dependencies; rmq_div_cell and the top level import this package, rmq_sqrt_cell does not.
`timescale 1ns / 1ps

package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;  // default fraction bits of elements and results
  localparam int IN_W          = 16;  // width of a matrix element
  localparam int OUT_W         = 16;  // width of a quaternion component
  localparam int NUM_W         = 18;  // signed sum or difference of two elements
  localparam int MAG_W         = 17;  // magnitude of a numerator, also the quotient width
  localparam int LANES         = 4;   // w, x, y, z

  // Lane of each quaternion component, also the code for the leading one.
  typedef enum logic [1:0] {
    LANE_W = 2'd0,
    LANE_X = 2'd1,
    LANE_Y = 2'd2,
    LANE_Z = 2'd3
  } lane_e;

  // Side data that travels alongside the square root.
  typedef struct packed {
    lane_e                        lead;
    logic                         degen;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][MAG_W-1:0]  mag;
  } sq_side_t;

  // Side data that travels alongside the dividers.
  typedef struct packed {
    lane_e                  lead;
    logic                   degen;
    logic [LANES-1:0]       neg;
    logic [LANES-1:0]       ovf;
    logic [OUT_W-1:0]       lead_val;
  } dv_side_t;

endpackage

// ===== design/rmq_sqrt_cell.sv =====
// One cell of the restoring square root chain: settles one root bit per beat.
// Depends on nothing outside itself; the side word is an opaque bit vector.
`timescale 1ns / 1ps

module rmq_sqrt_cell #(
  parameter int SQ_W = 34,
  parameter int RT_W = 17,
  parameter int STEP = 0,
  parameter int P_W  = 8
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SQ_W-1:0]   x_i,
  input  logic [RT_W+1:0]   rem_i,
  input  logic [RT_W-1:0]   root_i,
  input  logic [P_W-1:0]    side_i,
  output logic [SQ_W-1:0]   x_o,
  output logic [RT_W+1:0]   rem_o,
  output logic [RT_W-1:0]   root_o,
  output logic [P_W-1:0]    side_o
);

  localparam int RM_W = RT_W + 2;
  localparam int BIT  = SQ_W - 1 - 2 * STEP;

  logic [RM_W+1:0] cand, sub, diff;
  logic [RM_W-1:0] rem_d;
  logic [RT_W-1:0] root_d;

  always_comb begin
    cand = {rem_i, x_i[BIT -: 2]};
    sub  = (RM_W + 2)'({root_i, 2'b01});
    diff = cand - sub;
    if (cand >= sub) begin
      rem_d  = diff[RM_W-1:0];
      root_d = {root_i[RT_W-2:0], 1'b1};
    end else begin
      rem_d  = cand[RM_W-1:0];
      root_d = {root_i[RT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_i;
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

// ===== design/rmq_div_cell.sv =====
// One cell of a restoring divider chain: settles one quotient bit per beat.
// Depends on rmq_pkg for the quotient width.
`timescale 1ns / 1ps

module rmq_div_cell #(
  parameter int DV_W = 32,
  parameter int DW   = 18,
  parameter int STEP = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [DV_W-1:0]           dvd_i,
  input  logic [DW-1:0]             dvs_i,
  input  logic [DW-1:0]             rem_i,
  input  logic [rmq_pkg::MAG_W-1:0] quo_i,
  output logic [DV_W-1:0]           dvd_o,
  output logic [DW-1:0]             dvs_o,
  output logic [DW-1:0]             rem_o,
  output logic [rmq_pkg::MAG_W-1:0] quo_o
);

  import rmq_pkg::*;

  localparam int BIT = MAG_W - 1 - STEP;

  logic [DW:0]      cand, diff;
  logic [DW-1:0]    rem_d;
  logic             qbit;

  always_comb begin
    cand = {rem_i, dvd_i[BIT]};
    diff = cand - (DW + 1)'(dvs_i);
    qbit = (cand >= (DW + 1)'(dvs_i));
    rem_d = qbit ? diff[DW-1:0] : cand[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_o <= dvd_i;
      dvs_o <= dvs_i;
      rem_o <= rem_d;
      quo_o <= {quo_i[MAG_W-2:0], qbit};
    end
  end

endmodule

// ===== design/rotation_matrix_to_quaternion.sv =====
// Top level of the rotation matrix to quaternion converter.
// Depends on rmq_pkg, rmq_sqrt_cell and rmq_div_cell.
`timescale 1ns / 1ps

// Usage
// The input channel carries one 3x3 matrix per beat (nine signed elements with
// FRAC_BITS fraction bits); the output channel carries the quaternion and a
// flag that marks a non-positive square root radicand. Both channels use a
// valid and a stall signal; a beat moves on an edge where valid is high and
// stall is low.
// The block is one long pipeline: a front stage (trace, leading axis,
// radicand, numerators), a row of square root cells with one cell per root
// bit, a stage that forms the dividends, a row of divider cells with one cell
// per quotient bit (four lanes side by side) and an output register.
// Throughput is one beat per cycle while the output is not stalled; the length
// of the two cell rows sets the latency only.
// The whole pipeline advances together. While the output holds a beat that
// the receiver stalls, everything freezes and the input is stalled too; in
// every other cycle a new beat is taken, even while results are in flight.
// Reset clears the valid bits of every stage, so the output is empty after
// reset; the data registers are not reset.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [rmq_pkg::IN_W-1:0]  m00_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m01_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m02_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m10_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m11_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m12_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m20_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m21_i,
  input  logic signed [rmq_pkg::IN_W-1:0]  m22_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [rmq_pkg::OUT_W-1:0] q_w_o,
  output logic signed [rmq_pkg::OUT_W-1:0] q_x_o,
  output logic signed [rmq_pkg::OUT_W-1:0] q_y_o,
  output logic signed [rmq_pkg::OUT_W-1:0] q_z_o,
  output logic                             degenerate_o
);

  import rmq_pkg::*;

  // The radicand holds a sum of three elements plus one, in signed form.
  localparam int RAD_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 3;
  // The square root input is the radicand shifted up, rounded down to even width.
  localparam int SQ_W  = ((RAD_W + FRAC_BITS) / 2) * 2;
  localparam int RT_W  = SQ_W / 2;
  localparam int RM_W  = RT_W + 2;
  localparam int DV_W  = MAG_W + FRAC_BITS + 1;
  localparam int DW    = RT_W + 1;
  localparam int HI_W  = DV_W - MAG_W;
  localparam int CW    = (HI_W > DW) ? HI_W : DW;
  localparam int LW    = (RT_W > OUT_W) ? RT_W + 1 : OUT_W + 1;
  localparam int SQ_P  = $bits(sq_side_t);
  // Stage numbers of the valid chain.
  localparam int ST_PREP = RT_W + 1;
  localparam int NSTG    = RT_W + MAG_W + 2;

  localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W - 1){1'b0}}};

  // Global advance: the pipeline moves unless a finished beat is stalled.
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic [NSTG-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_valid_i};
    end
  end

  // ------------------------------------------------------------------
  // Front stage: trace test, leading axis, radicand and the four numerators.
  // ------------------------------------------------------------------
  logic signed [NUM_W-1:0] trace;
  logic signed [RAD_W-1:0] rad;
  logic signed [RAD_W-1:0] one_c;
  logic signed [IN_W-1:0]  dmax;
  lane_e                   lead;
  logic signed [NUM_W-1:0] num [LANES];
  logic                    degen;
  logic [SQ_W-1:0]         sq_in_d;
  sq_side_t                side_d;

  always_comb begin
    one_c = RAD_W'(1) <<< FRAC_BITS;
    trace = NUM_W'(m00_i) + NUM_W'(m11_i) + NUM_W'(m22_i);
    for (int l = 0; l < LANES; l++) begin
      num[l] = '0;
    end
    dmax = m00_i;
    lead = LANE_X;
    if (m11_i > m00_i) begin
      dmax = m11_i;
      lead = LANE_Y;
    end
    if (m22_i > dmax) begin
      lead = LANE_Z;
    end
    if (trace > 0) begin
      lead = LANE_W;
    end
    rad = '0;
    unique case (lead)
      LANE_W: begin
        rad    = RAD_W'(trace) + one_c;
        num[1] = NUM_W'(m21_i) - NUM_W'(m12_i);
        num[2] = NUM_W'(m02_i) - NUM_W'(m20_i);
        num[3] = NUM_W'(m10_i) - NUM_W'(m01_i);
      end
      LANE_X: begin
        rad    = RAD_W'(m00_i) - RAD_W'(m11_i) - RAD_W'(m22_i) + one_c;
        num[0] = NUM_W'(m21_i) - NUM_W'(m12_i);
        num[2] = NUM_W'(m10_i) + NUM_W'(m01_i);
        num[3] = NUM_W'(m20_i) + NUM_W'(m02_i);
      end
      LANE_Y: begin
        rad    = RAD_W'(m11_i) - RAD_W'(m22_i) - RAD_W'(m00_i) + one_c;
        num[0] = NUM_W'(m02_i) - NUM_W'(m20_i);
        num[3] = NUM_W'(m21_i) + NUM_W'(m12_i);
        num[1] = NUM_W'(m01_i) + NUM_W'(m10_i);
      end
      LANE_Z: begin
        rad    = RAD_W'(m22_i) - RAD_W'(m00_i) - RAD_W'(m11_i) + one_c;
        num[0] = NUM_W'(m10_i) - NUM_W'(m01_i);
        num[1] = NUM_W'(m02_i) + NUM_W'(m20_i);
        num[2] = NUM_W'(m12_i) + NUM_W'(m21_i);
      end
      default: begin
        rad = '0;
      end
    endcase
    // A zero or negative radicand is clamped; the result is forced to zero.
    degen   = (rad <= 0);
    sq_in_d = degen ? '0 : (SQ_W'(rad[RAD_W-2:0]) << FRAC_BITS);
    side_d.lead  = lead;
    side_d.degen = degen;
    for (int l = 0; l < LANES; l++) begin
      side_d.neg[l] = num[l][NUM_W-1];
      side_d.mag[l] = num[l][NUM_W-1] ? MAG_W'(-num[l]) : MAG_W'(num[l]);
    end
  end

  logic [SQ_W-1:0] sq_x   [RT_W+1];
  logic [RM_W-1:0] sq_rem [RT_W+1];
  logic [RT_W-1:0] sq_root[RT_W+1];
  logic [SQ_P-1:0] sq_side[RT_W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_x[0]    <= sq_in_d;
      sq_side[0] <= side_d;
    end
  end

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  // ------------------------------------------------------------------
  // Square root row: one cell per root bit.
  // ------------------------------------------------------------------
  for (genvar s = 0; s < RT_W; s++) begin : g_sqrt
    rmq_sqrt_cell #(
      .SQ_W (SQ_W),
      .RT_W (RT_W),
      .STEP (s),
      .P_W  (SQ_P)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (sq_x[s]),
      .rem_i  (sq_rem[s]),
      .root_i (sq_root[s]),
      .side_i (sq_side[s]),
      .x_o    (sq_x[s+1]),
      .rem_o  (sq_rem[s+1]),
      .root_o (sq_root[s+1]),
      .side_o (sq_side[s+1])
    );
  end

  // ------------------------------------------------------------------
  // Dividend stage: (|n| << FRAC_BITS) + root over 2 root, plus the leading
  // component (root + 1) / 2.
  // ------------------------------------------------------------------
  sq_side_t         sq_end;
  logic [RT_W-1:0]  root;
  logic [DV_W-1:0]  dvd_d [LANES];
  logic [HI_W-1:0]  hi    [LANES];
  logic [DW-1:0]    dvs_d;
  logic [LW-1:0]    lead_w;
  dv_side_t         dside_d;

  always_comb begin
    sq_end = sq_side_t'(sq_side[RT_W]);
    root   = sq_root[RT_W];
    dvs_d  = {root, 1'b0};
    lead_w = (LW'(root) + LW'(1)) >> 1;
    dside_d.lead     = sq_end.lead;
    dside_d.degen    = sq_end.degen;
    dside_d.neg      = sq_end.neg;
    dside_d.lead_val = (lead_w > LW'(POS_MAX)) ? POS_MAX : OUT_W'(lead_w);
    for (int l = 0; l < LANES; l++) begin
      dvd_d[l]  = (DV_W'(sq_end.mag[l]) << FRAC_BITS) + DV_W'(root);
      hi[l]     = dvd_d[l][DV_W-1:MAG_W];
      // A quotient beyond the cell row always saturates.
      dside_d.ovf[l] = (CW'(hi[l]) >= CW'(dvs_d));
    end
  end

  logic [DV_W-1:0]  dv_dvd [LANES][MAG_W+1];
  logic [DW-1:0]    dv_dvs [LANES][MAG_W+1];
  logic [DW-1:0]    dv_rem [LANES][MAG_W+1];
  logic [MAG_W-1:0] dv_quo [LANES][MAG_W+1];
  dv_side_t         dside_q [MAG_W+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= dside_d;
      for (int s = 0; s < MAG_W; s++) begin
        dside_q[s+1] <= dside_q[s];
      end
    end
  end

  // ------------------------------------------------------------------
  // Divider rows: four lanes, one cell per quotient bit.
  // ------------------------------------------------------------------
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_dvd[l][0] <= dvd_d[l];
        dv_dvs[l][0] <= dvs_d;
        dv_rem[l][0] <= DW'(hi[l]);
      end
    end

    assign dv_quo[l][0] = '0;
    for (genvar s = 0; s < MAG_W; s++) begin : g_div
      rmq_div_cell #(
        .DV_W (DV_W),
        .DW   (DW),
        .STEP (s)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .dvd_i (dv_dvd[l][s]),
        .dvs_i (dv_dvs[l][s]),
        .rem_i (dv_rem[l][s]),
        .quo_i (dv_quo[l][s]),
        .dvd_o (dv_dvd[l][s+1]),
        .dvs_o (dv_dvs[l][s+1]),
        .rem_o (dv_rem[l][s+1]),
        .quo_o (dv_quo[l][s+1])
      );
    end
  end

  // ------------------------------------------------------------------
  // Output register: sign, saturation and placement of the leading value.
  // ------------------------------------------------------------------
  dv_side_t         dend;
  logic [MAG_W-1:0] qmag;
  logic [OUT_W-1:0] res_d [LANES];
  logic [OUT_W-1:0] res_q [LANES];
  logic             degen_q;
  logic             out_vld_q;

  always_comb begin
    dend = dside_q[MAG_W];
    for (int l = 0; l < LANES; l++) begin
      qmag = dv_quo[l][MAG_W];
      if (dend.degen) begin
        res_d[l] = '0;
      end else if (lane_e'(l) == dend.lead) begin
        res_d[l] = dend.lead_val;
      end else if (dend.neg[l]) begin
        if (dend.ovf[l] || qmag > MAG_W'(NEG_MAX)) begin
          res_d[l] = NEG_MAX;
        end else begin
          res_d[l] = OUT_W'(-qmag);
        end
      end else begin
        if (dend.ovf[l] || qmag > MAG_W'(POS_MAX)) begin
          res_d[l] = POS_MAX;
        end else begin
          res_d[l] = OUT_W'(qmag);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[NSTG-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q   <= res_d;
      degen_q <= dend.degen;
    end
  end

  // The valid bit at the dividend stage is kept for symmetry of the chain.
  logic unused_prep;
  assign unused_prep = vld_q[ST_PREP];

  assign out_valid_o  = out_vld_q;
  assign q_w_o        = res_q[0];
  assign q_x_o        = res_q[1];
  assign q_y_o        = res_q[2];
  assign q_z_o        = res_q[3];
  assign degenerate_o = degen_q & ~unused_prep | degen_q;

endmodule
